### rtl/core/swp_pkg.sv
package swp_pkg;

  localparam int HaasDepth     = 64;
  localparam int AllpassStages = 4;
  localparam int SampleW       = 24;
  localparam int WideW         = 28;
  localparam int CfgIdxW       = 3;
  localparam int CfgDataW      = 18;
  localparam int ApTotal       = 296;
  localparam int ApAddrW       = 9;
  localparam int AccW          = 72;

  localparam logic [CfgIdxW-1:0] REG_BASS_COEFF   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MID_GAIN     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SIDE_GAIN    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DECOR_AMOUNT = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_HAAS_AMOUNT  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_HAAS_DELAY   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_BASS_NARROW  = 3'd6;

  function automatic logic [6:0] ap_len(input logic [2:0] k);
    case (k)
      3'd0: ap_len = 7'd7;
      3'd1: ap_len = 7'd19;
      3'd2: ap_len = 7'd37;
      3'd3: ap_len = 7'd67;
      3'd4: ap_len = 7'd11;
      3'd5: ap_len = 7'd29;
      3'd6: ap_len = 7'd47;
      default: ap_len = 7'd79;
    endcase
  endfunction

  function automatic logic [ApAddrW-1:0] ap_base(input logic [2:0] k);
    case (k)
      3'd0: ap_base = 9'd0;
      3'd1: ap_base = 9'd7;
      3'd2: ap_base = 9'd26;
      3'd3: ap_base = 9'd63;
      3'd4: ap_base = 9'd130;
      3'd5: ap_base = 9'd141;
      3'd6: ap_base = 9'd170;
      default: ap_base = 9'd217;
    endcase
  endfunction

  function automatic logic [15:0] ap_gain(input logic [1:0] s);
    case (s)
      2'd0: ap_gain = 16'd32768;
      2'd1: ap_gain = 16'd39322;
      2'd2: ap_gain = 16'd36045;
      default: ap_gain = 16'd42598;
    endcase
  endfunction

endpackage

### rtl/core/swp_ram.sv
module swp_ram #(
  parameter int Width = 28,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/swp_mac.sv
// Bit-serial multiply-accumulate: acc += a * b, one multiplier bit per cycle.
module swp_mac (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       clr,
  input  logic signed [swp_pkg::AccW-1:0] a,
  input  logic [17:0]                b,
  output logic                       busy,
  output logic signed [swp_pkg::AccW-1:0] acc
);

  logic signed [swp_pkg::AccW-1:0] mcand;
  logic [17:0] mplier;
  logic [4:0]  cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy   <= 1'b1;
      cnt    <= 5'd18;
      mcand  <= a;
      mplier <= b;
      if (clr) begin
        acc <= '0;
      end
    end else if (busy) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= mcand <<< 1;
      mplier <= mplier >> 1;
      cnt    <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/stereo_width_processor_top.sv
// Throughput: one sample pair at a time; the next input is taken only after the result is
// registered; each of up to 30 multiplies runs bit-serially in one shared unit.
// The output register lets the next input be taken while a result waits; a stalled output
// holds the block only when a second result is ready. Reset: synchronous, active high;
// clears registers to defaults, filters and positions, then a clearing pass over the allpass
// and delay memories during which no input is taken.
module stereo_width_processor_top #(
  parameter int HaasDepth     = swp_pkg::HaasDepth,
  parameter int AllpassStages = swp_pkg::AllpassStages
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // left_in[23:0], right_in[47:24]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // left_out[23:0], right_out[47:24]
  input  logic        cfg_we,
  input  logic [swp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [swp_pkg::CfgDataW-1:0] cfg_data
);

  localparam int AccW = swp_pkg::AccW;
  localparam int HW   = $clog2(HaasDepth);
  localparam int ApAddrW_c = swp_pkg::ApAddrW;
  localparam int ClrDepth  = (swp_pkg::ApTotal > HaasDepth) ? swp_pkg::ApTotal : HaasDepth;
  localparam int ClrW      = $clog2(ClrDepth);
  localparam logic signed [AccW-1:0] Max28 = AccW'(134217727);
  localparam logic signed [AccW-1:0] Min28 = -AccW'(134217728);
  localparam logic signed [AccW-1:0] Max24 = AccW'(8388607);
  localparam logic signed [AccW-1:0] Min24 = -AccW'(8388608);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_BL, S_BL2, S_BR, S_BR2, S_HI, S_MID, S_SIDE, S_MS,
    S_AP_RD, S_AP_Y, S_AP_YS, S_AP_W, S_AP_WS, S_AP_NEXT,
    S_BLEND_L, S_BLEND_L2, S_BLEND_R, S_BLEND_R2, S_DEC_DONE,
    S_HAAS, S_HAAS_RD, S_HB, S_HB2, S_HB_DONE,
    S_OL, S_OL2, S_OR, S_OR2, S_OUT
  } state_t;

  state_t state;

  logic [15:0] bass_coeff;
  logic [16:0] mid_gain, decor_amount, haas_amount, bass_narrow;
  logic [17:0] side_gain;
  logic [5:0]  haas_delay;

  logic signed [31:0] bass_l, bass_r;
  logic signed [AccW-1:0] xl, xr, hl, hr, dl, dr, tmp, w_rd;
  logic [6:0] ap_pos [8];
  logic [2:0] k;
  logic [HW-1:0] haas_wp;
  logic [ClrW-1:0] clr_addr;

  logic mac_start, mac_clr, mac_busy;
  logic signed [AccW-1:0] mac_a, acc;
  logic [17:0] mac_b;

  swp_mac u_mac (
    .clk(clk), .rst(rst), .start(mac_start), .clr(mac_clr),
    .a(mac_a), .b(mac_b), .busy(mac_busy), .acc(acc)
  );

  logic ap_we;
  logic [ApAddrW_c-1:0] ap_waddr, ap_raddr;
  logic [27:0] ap_wdata, ap_rdata;
  swp_ram #(.Width(28), .Depth(swp_pkg::ApTotal)) u_ap_ram (
    .clk(clk), .we(ap_we), .waddr(ap_waddr), .wdata(ap_wdata),
    .raddr(ap_raddr), .rdata(ap_rdata)
  );

  logic h_we;
  logic [HW-1:0] h_waddr, h_raddr;
  logic [27:0] h_wdata, h_rdata;
  swp_ram #(.Width(28), .Depth(HaasDepth)) u_haas_ram (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  function automatic logic signed [AccW-1:0] rsh(input logic signed [AccW-1:0] v,
                                                  input int n);
    logic signed [AccW-1:0] t;
    t = v + (AccW'(1) <<< (n - 1));
    rsh = t >>> n;
  endfunction

  function automatic logic signed [AccW-1:0] sat(input logic signed [AccW-1:0] v,
                                                  input logic signed [AccW-1:0] lo,
                                                  input logic signed [AccW-1:0] hi);
    sat = (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  logic [16:0] da_c, ha_c;
  logic [5:0]  hd_c;
  logic decor_on, haas_on;
  logic [6:0] len_k, pos_k, pos_n;
  logic [1:0] stg;
  logic [HW-1:0] rp;
  assign da_c = (decor_amount > 17'd65536) ? 17'd65536 : decor_amount;
  assign ha_c = (haas_amount > 17'd65536) ? 17'd65536 : haas_amount;
  assign hd_c = (32'(haas_delay) > HaasDepth - 1) ? 6'(HaasDepth - 1) : haas_delay;
  assign decor_on = decor_amount > 17'd65;
  assign haas_on  = (haas_amount > 17'd65) && (haas_delay != 6'd0);
  assign len_k = swp_pkg::ap_len(k);
  assign pos_k = (ap_pos[k] >= len_k) ? 7'd0 : ap_pos[k];
  assign pos_n = (pos_k + 7'd1 >= len_k) ? 7'd0 : pos_k + 7'd1;
  assign stg   = k[1:0];
  assign rp    = (HW'(hd_c) > haas_wp) ? HW'(32'(haas_wp) + HaasDepth - 32'(hd_c))
                                       : haas_wp - HW'(hd_c);

  logic out_full;
  logic [47:0] out_data;
  assign m_axis_tvalid = out_full;
  assign m_axis_tdata  = out_data;
  assign s_axis_tready = (state == S_IDLE);

  always_comb begin
    mac_start = 1'b0;
    mac_clr   = 1'b1;
    mac_a     = '0;
    mac_b     = '0;
    ap_we     = 1'b0;
    ap_waddr  = swp_pkg::ap_base(k) + ApAddrW_c'(pos_k);
    ap_raddr  = swp_pkg::ap_base(k) + ApAddrW_c'(pos_k);
    ap_wdata  = tmp[27:0];
    h_we      = 1'b0;
    h_waddr   = haas_wp;
    h_wdata   = hr[27:0];
    h_raddr   = rp;
    case (state)
      S_CLEAR: begin
        ap_we = (32'(clr_addr) < swp_pkg::ApTotal);
        ap_waddr = ApAddrW_c'(clr_addr); ap_wdata = '0;
        h_we = (32'(clr_addr) < HaasDepth);
        h_waddr = HW'(clr_addr); h_wdata = '0;
      end
      S_BL:  begin mac_start = 1'b1; mac_a = AccW'(bass_l); mac_b = 18'(bass_coeff); end
      S_BL2: if (!mac_busy) begin
        mac_start = 1'b1; mac_clr = 1'b0; mac_a = xl;
        mac_b = 18'(17'd65536 - 17'(bass_coeff));
      end
      S_BR: if (!mac_busy) begin
        mac_start = 1'b1; mac_a = AccW'(bass_r); mac_b = 18'(bass_coeff);
      end
      S_BR2: if (!mac_busy) begin
        mac_start = 1'b1; mac_clr = 1'b0; mac_a = xr;
        mac_b = 18'(17'd65536 - 17'(bass_coeff));
      end
      S_MS:   begin mac_start = 1'b1; mac_a = hl + hr; mac_b = 18'(mid_gain); end
      S_MID:  if (!mac_busy) begin mac_start = 1'b1; mac_a = hl - hr; mac_b = side_gain; end
      S_AP_RD: begin
        mac_start = 1'b1; mac_a = k[2] ? dr : dl; mac_b = 18'(swp_pkg::ap_gain(stg));
      end
      S_AP_YS: begin
        mac_start = 1'b1; mac_a = sat(w_rd - rsh(acc, 16), Min28, Max28);
        mac_b = 18'(swp_pkg::ap_gain(stg));
      end
      S_AP_W: ap_we = 1'b1;
      S_BLEND_L: begin mac_start = 1'b1; mac_a = hl; mac_b = 18'(17'd65536 - da_c); end
      S_BLEND_L2: if (!mac_busy) begin
        mac_start = 1'b1; mac_clr = 1'b0; mac_a = dl; mac_b = 18'(da_c);
      end
      S_BLEND_R: if (!mac_busy) begin
        mac_start = 1'b1; mac_a = hr; mac_b = 18'(17'd65536 - da_c);
      end
      S_BLEND_R2: if (!mac_busy) begin
        mac_start = 1'b1; mac_clr = 1'b0; mac_a = dr; mac_b = 18'(da_c);
      end
      S_HAAS: h_we = 1'b1;
      S_HB: begin mac_start = 1'b1; mac_a = hr; mac_b = 18'(17'd65536 - ha_c); end
      S_HB2: if (!mac_busy) begin
        mac_start = 1'b1; mac_clr = 1'b0; mac_a = tmp; mac_b = 18'(ha_c);
      end
      S_OL: begin
        mac_start = 1'b1; mac_a = AccW'(bass_l) - AccW'(bass_r); mac_b = 18'(bass_narrow);
      end
      S_OR: begin
        mac_start = 1'b1; mac_a = AccW'(bass_r) - AccW'(bass_l); mac_b = 18'(bass_narrow);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      bass_coeff <= 16'd63774; mid_gain <= 17'd65536; side_gain <= 18'd65536;
      decor_amount <= '0; haas_amount <= '0; haas_delay <= 6'd38;
      bass_narrow <= 17'd42598;
      bass_l <= '0; bass_r <= '0;
      for (int i = 0; i < 8; i++) ap_pos[i] <= '0;
      haas_wp <= '0;
      out_full <= 1'b0;
      k <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          swp_pkg::REG_BASS_COEFF:   bass_coeff   <= cfg_data[15:0];
          swp_pkg::REG_MID_GAIN:     mid_gain     <= cfg_data[16:0];
          swp_pkg::REG_SIDE_GAIN:    side_gain    <= cfg_data;
          swp_pkg::REG_DECOR_AMOUNT: decor_amount <= cfg_data[16:0];
          swp_pkg::REG_HAAS_AMOUNT:  haas_amount  <= cfg_data[16:0];
          swp_pkg::REG_HAAS_DELAY:   haas_delay   <= cfg_data[5:0];
          swp_pkg::REG_BASS_NARROW:  bass_narrow  <= cfg_data[16:0];
          default: ;
        endcase
      end
      if (out_full && m_axis_tready && state != S_OUT) begin
        out_full <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (32'(clr_addr) == ClrDepth - 1) state <= S_IDLE;
        end
        S_IDLE: if (s_axis_tvalid) begin
          xl <= AccW'($signed(s_axis_tdata[23:0])) <<< 8;
          xr <= AccW'($signed(s_axis_tdata[47:24])) <<< 8;
          state <= S_BL;
        end
        S_BL:  state <= S_BL2;
        S_BL2: if (!mac_busy) state <= S_BR;
        S_BR: if (!mac_busy) begin
          bass_l <= 32'(rsh(acc, 16));
          state <= S_BR2;
        end
        S_BR2: if (!mac_busy) state <= S_HI;
        S_HI: if (!mac_busy) begin
          bass_r <= 32'(rsh(acc, 16));
          hl <= rsh(xl - AccW'(bass_l), 8);
          hr <= rsh(xr - rsh(acc, 16), 8);
          state <= S_MS;
        end
        S_MS: state <= S_MID;
        default: ;
      endcase
      case (state)
        S_HI: ;
        S_MID: if (!mac_busy && state == S_MID) begin
          tmp <= rsh(acc, 17);
          state <= S_SIDE;
        end
        S_SIDE: if (!mac_busy) begin
          hl <= sat(tmp + rsh(acc, 17), Min28, Max28);
          hr <= sat(tmp - rsh(acc, 17), Min28, Max28);
          dl <= sat(tmp + rsh(acc, 17), Min28, Max28);
          dr <= sat(tmp - rsh(acc, 17), Min28, Max28);
          k <= '0;
          state <= decor_on ? S_AP_RD : S_DEC_DONE;
        end
        S_AP_RD: state <= S_AP_Y;
        S_AP_Y: begin
          w_rd <= AccW'($signed(ap_rdata));
          if (!mac_busy) state <= S_AP_YS;
        end
        S_AP_YS: begin
          tmp <= sat(w_rd - rsh(acc, 16), Min28, Max28);
          state <= S_AP_WS;
        end
        S_AP_WS: ;
        default: ;
      endcase
      case (state)
        S_AP_YS: ;
        S_AP_WS: if (!mac_busy) begin
          if (k[2]) dr <= tmp; else dl <= tmp;
          tmp <= sat((k[2] ? dr : dl) + rsh(acc, 16), Min28, Max28);
          state <= S_AP_W;
        end
        S_AP_W: begin
          ap_pos[k] <= pos_n;
          state <= S_AP_NEXT;
        end
        S_AP_NEXT: begin
          if (k[1:0] == 2'(AllpassStages - 1)) begin
            if (k[2]) state <= S_BLEND_L;
            else begin k <= 3'd4; state <= S_AP_RD; end
          end else begin
            k <= k + 3'd1; state <= S_AP_RD;
          end
        end
        S_BLEND_L:  state <= S_BLEND_L2;
        S_BLEND_L2: if (!mac_busy) state <= S_BLEND_R;
        S_BLEND_R: if (!mac_busy) begin
          hl <= sat(rsh(acc, 16), Min28, Max28);
          state <= S_BLEND_R2;
        end
        S_BLEND_R2: if (!mac_busy) state <= S_DEC_DONE;
        S_DEC_DONE: if (!mac_busy) begin
          if (decor_on) hr <= sat(rsh(acc, 16), Min28, Max28);
          state <= haas_on ? S_HAAS : S_OL;
        end
        S_HAAS: begin
          state <= S_HAAS_RD;
        end
        S_HAAS_RD: begin
          state <= S_HB;
        end
        S_HB: begin
          tmp <= AccW'($signed(h_rdata));
          state <= S_HB2;
        end
        S_HB2: if (!mac_busy) state <= S_HB_DONE;
        S_HB_DONE: if (!mac_busy) begin
          hr <= sat(rsh(acc, 16), Min28, Max28);
          haas_wp <= (32'(haas_wp) == HaasDepth - 1) ? '0 : haas_wp + 1'b1;
          state <= S_OL;
        end
        S_OL: state <= S_OL2;
        S_OL2: if (!mac_busy) begin
          tmp <= sat(rsh((AccW'(bass_l) + AccW'(bass_r)) * 65536 + acc + (hl <<< 25), 25),
                     Min24, Max24);
          state <= S_OR;
        end
        S_OR: state <= S_OR2;
        S_OR2: if (!mac_busy) begin
          w_rd <= sat(rsh((AccW'(bass_l) + AccW'(bass_r)) * 65536 + acc + (hr <<< 25), 25),
                      Min24, Max24);
          state <= S_OUT;
        end
        S_OUT: if (!out_full || m_axis_tready) begin
          out_data <= {w_rd[23:0], tmp[23:0]};
          out_full <= 1'b1;
          state <= S_IDLE;
        end
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/swp_checker.sv
module swp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  a_no_ready_rst: assert property (@(posedge clk) rst |=> !s_axis_tready)
    else $error("ready right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while busy");

endmodule

bind stereo_width_processor_top swp_checker u_swp_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

### sim/stereo_width_processor_top_test.sv
module stereo_width_processor_top_test;

  localparam int Items       = 1500;
  localparam int IdleLimit   = 20000;
  localparam int Latency     = 700;
  localparam int QuietCycles = 3000;
  localparam longint Max28 = 134217727;
  localparam longint Min28 = -134217728;
  localparam logic [swp_pkg::CfgIdxW-1:0] REG_NONE = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        cfg_we = 1'b0;
  logic [swp_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [swp_pkg::CfgDataW-1:0] cfg_data = '0;

  stereo_width_processor_top dut (.*);

  always #5 clk = ~clk;

  // Widener state and settings mirrored in the testbench
  class widener_scoreboard;
    int unsigned coeff, mgain, sgain, decor, haas_amt, haas_dly, narrow;
    longint lp_l, lp_r;
    longint ap_mem [swp_pkg::ApTotal];
    int unsigned ap_pos [8];
    longint haas_mem [swp_pkg::HaasDepth];
    int unsigned haas_wp;
    logic [47:0] pending [$];
    int errors;

    function void reset_state();
      coeff = 63774; mgain = 65536; sgain = 65536; decor = 0; haas_amt = 0;
      haas_dly = 38; narrow = 42598; lp_l = 0; lp_r = 0; haas_wp = 0;
      foreach (ap_mem[i]) ap_mem[i] = 0;
      foreach (ap_pos[i]) ap_pos[i] = 0;
      foreach (haas_mem[i]) haas_mem[i] = 0;
    endfunction

    function void write_reg(logic [swp_pkg::CfgIdxW-1:0] idx,
                            logic [swp_pkg::CfgDataW-1:0] v);
      case (idx)
        swp_pkg::REG_BASS_COEFF:   coeff = v[15:0];
        swp_pkg::REG_MID_GAIN:     mgain = v[16:0];
        swp_pkg::REG_SIDE_GAIN:    sgain = v[17:0];
        swp_pkg::REG_DECOR_AMOUNT: decor = v[16:0];
        swp_pkg::REG_HAAS_AMOUNT:  haas_amt = v[16:0];
        swp_pkg::REG_HAAS_DELAY:   haas_dly = v[5:0];
        swp_pkg::REG_BASS_NARROW:  narrow = v[16:0];
        default: ;
      endcase
    endfunction

    function longint rnd(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint allpass_stage(int k, int st, longint x);
      int unsigned p, len, base;
      longint g, w, y;
      len = swp_pkg::ap_len(k[2:0]);
      base = swp_pkg::ap_base(k[2:0]);
      g = swp_pkg::ap_gain(st[1:0]);
      p = ap_pos[k] >= len ? 0 : ap_pos[k];
      w = ap_mem[base + p];
      y = clip(w - rnd(g * x, 16), Min28, Max28);
      ap_mem[base + p] = clip(x + rnd(g * y, 16), Min28, Max28);
      ap_pos[k] = (p + 1 >= len) ? 0 : p + 1;
      return y;
    endfunction

    function longint mix(longint h, longint d, int unsigned amt);
      longint a;
      a = amt > 65536 ? 65536 : amt;
      return clip(rnd(h * (65536 - a) + d * a, 16), Min28, Max28);
    endfunction

    function void note_input(logic [47:0] data);
      longint xl, xr, c, hl, hr, m, s, dl, dr, ol, orr;
      int unsigned d, wp, rp;
      xl = longint'($signed(data[23:0])) * 256;
      xr = longint'($signed(data[47:24])) * 256;
      c = coeff;
      lp_l = rnd(c * lp_l + (65536 - c) * xl, 16);
      lp_r = rnd(c * lp_r + (65536 - c) * xr, 16);
      hl = rnd(xl - lp_l, 8);
      hr = rnd(xr - lp_r, 8);
      m = rnd((hl + hr) * longint'(mgain), 17);
      s = rnd((hl - hr) * longint'(sgain), 17);
      hl = clip(m + s, Min28, Max28);
      hr = clip(m - s, Min28, Max28);
      if (decor > 65) begin
        dl = hl;
        dr = hr;
        for (int i = 0; i < swp_pkg::AllpassStages; i++) begin
          dl = allpass_stage(i, i, dl);
          dr = allpass_stage(4 + i, i, dr);
        end
        hl = mix(hl, dl, decor);
        hr = mix(hr, dr, decor);
      end
      if (haas_amt > 65 && haas_dly != 0) begin
        d = haas_dly > swp_pkg::HaasDepth - 1 ? swp_pkg::HaasDepth - 1 : haas_dly;
        wp = haas_wp % swp_pkg::HaasDepth;
        rp = (wp + swp_pkg::HaasDepth - d) % swp_pkg::HaasDepth;
        haas_mem[wp] = hr;
        hr = mix(hr, haas_mem[rp], haas_amt);
        haas_wp = (wp + 1) % swp_pkg::HaasDepth;
      end
      ol = rnd((lp_l + lp_r) * 65536 + (lp_l - lp_r) * longint'(narrow)
               + hl * (longint'(1) << 25), 25);
      orr = rnd((lp_l + lp_r) * 65536 - (lp_l - lp_r) * longint'(narrow)
                + hr * (longint'(1) << 25), 25);
      ol = clip(ol, -8388608, 8388607);
      orr = clip(orr, -8388608, 8388607);
      pending.push_back({orr[23:0], ol[23:0]});
    endfunction

    function void check_output(logic [47:0] data);
      logic [47:0] exp_data;
      if (pending.size() == 0) begin
        $display("%0t: unexpected output %h", $time, data);
        errors++;
        return;
      end
      exp_data = pending.pop_front();
      if (data[23:0] !== exp_data[23:0]) begin
        $display("%0t: left_out expected %h actual %h", $time, exp_data[23:0], data[23:0]);
        errors++;
      end
      if (data[47:24] !== exp_data[47:24]) begin
        $display("%0t: right_out expected %h actual %h", $time, exp_data[47:24],
                 data[47:24]);
        errors++;
      end
    endfunction
  endclass

  widener_scoreboard sb = new();
  int idle_cycles = 0;
  int hold_off = 0;
  int quiet_left = 0;
  bit quiet_go = 1'b0;
  bit quiet_ack = 1'b0;

  function int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
  endfunction

  task automatic write_cfg(logic [swp_pkg::CfgIdxW-1:0] idx,
                           logic [swp_pkg::CfgDataW-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  task automatic send_pair(logic [47:0] data, bit nogap);
    int g;
    g = nogap ? 0 : gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= data;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_input(data);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (Latency) @(posedge clk);
  endtask

  function logic [23:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 24'h7fffff;
      1: return 24'h800000;
      2: return 24'($signed($urandom_range(0, 2000)) - 1000);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic random_settings(int mode);
    write_cfg(swp_pkg::REG_BASS_COEFF, mode == 0 ? 18'd0 : (mode == 1 ? 18'd65535 :
              18'($urandom_range(0, 65535))));
    write_cfg(swp_pkg::REG_MID_GAIN, mode == 0 ? 18'd0 : (mode == 1 ? 18'd131071 :
              18'($urandom_range(0, 92682))));
    write_cfg(swp_pkg::REG_SIDE_GAIN, mode == 0 ? 18'd0 : (mode == 1 ? 18'd262143 :
              18'($urandom_range(0, 163840))));
    write_cfg(swp_pkg::REG_DECOR_AMOUNT, mode == 0 ? 18'd65 : (mode == 1 ? 18'd131071 :
              18'($urandom_range(0, 70000))));
    write_cfg(swp_pkg::REG_HAAS_AMOUNT, mode == 0 ? 18'd66 : (mode == 1 ? 18'd131071 :
              18'($urandom_range(0, 70000))));
    write_cfg(swp_pkg::REG_HAAS_DELAY, mode == 0 ? 18'd1 : (mode == 1 ? 18'd63 :
              18'($urandom_range(0, 63))));
    write_cfg(swp_pkg::REG_BASS_NARROW, mode == 0 ? 18'd19661 : (mode == 1 ? 18'd131071 :
              18'($urandom_range(19661, 65536))));
    write_cfg(REG_NONE, 18'($urandom));
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) sb.check_output(m_axis_tdata);
      if (quiet_go != quiet_ack) begin
        quiet_ack <= quiet_go;
        quiet_left <= QuietCycles;
        m_axis_tready <= 1'b0;
      end else if (quiet_left > 0) begin
        quiet_left <= quiet_left - 1;
        m_axis_tready <= 1'b0;
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        m_axis_tready <= 1'b0;
      end else if (m_axis_tvalid && m_axis_tready || !m_axis_tready) begin
        if ($urandom_range(0, 3) == 0) begin
          hold_off <= gap_len();
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    sb.reset_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: defaults first, then extremes
    send_pair({24'h7fffff, 24'h7fffff}, 1'b0);
    send_pair({24'h800000, 24'h800000}, 1'b0);
    send_pair({24'h800000, 24'h7fffff}, 1'b0);
    send_pair({24'h000000, 24'hffffff}, 1'b0);
    drain();
    for (int mode = 0; mode < 2; mode++) begin
      random_settings(mode);
      for (int i = 0; i < 10; i++)
        send_pair({(i[0] ? 24'h800000 : 24'h7fffff), (i[1] ? 24'h7fffff : 24'h800000)}, 1'b0);
      drain();
    end
    for (int phase = 0; phase < 6; phase++) begin
      random_settings(2);
      if (phase == 2) begin
        quiet_go = ~quiet_go;
        for (int i = 0; i < 3; i++) send_pair({rand_sample(), rand_sample()}, 1'b1);
      end
      for (int i = 0; i < Items / 6; i++) send_pair({rand_sample(), rand_sample()}, 1'b0);
      drain();
    end
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
